// ===== hdl/srtsch_pkg.sv =====
// Shared types and constants for the array store / sort / search core.
// Holds the item structs, request kinds and status codes.
// No dependencies.
package srtsch_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned FILL_W    = 4;
  localparam int unsigned DEPTH_DEF = 8;

  // Request kinds
  typedef enum logic [2:0] {
    REQ_PUSH     = 3'd0,
    REQ_POP      = 3'd1,
    REQ_MODPOS   = 3'd2,
    REQ_MODVAL   = 3'd3,
    REQ_SORT     = 3'd4,
    REQ_READPOS  = 3'd5,
    REQ_LSEARCH  = 3'd6,
    REQ_BSEARCH  = 3'd7
  } req_kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } status_t;

  typedef struct packed {
    req_kind_t                  req_type;
    logic signed [WORD_W-1:0]   key;
    logic signed [WORD_W-1:0]   new_value;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic signed [WORD_W-1:0]   result_value;
    logic [POS_W-1:0]           result_position;
    logic [FILL_W-1:0]          fill_level;
    logic                       last;
  } out_item_t;

endpackage

// ===== hdl/srtsch_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module srtsch_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/array_store_sort_search_core.sv =====
// Top level of the array store: stack of signed words with sort and search.
// Depends on srtsch_pkg and srtsch_ram.
//
//  channel | ports                           | direction | accepted when
//  --------+---------------------------------+-----------+----------------------
//  input   | in_valid, in_stall, in_item     | in        | in_valid & !in_stall
//  result  | out_valid, out_stall, out_item  | out       | out_valid & !out_stall
//
// One item at a time; in_stall is high from acceptance until the final result
// is in the output register. One RAM read port with registered data. Output
// stalls hold the sequencer. Reset empties the store; there is no clearing
// pass.
module array_store_sort_search_core #(
  parameter int unsigned DEPTH = srtsch_pkg::DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  srtsch_pkg::in_item_t   in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output srtsch_pkg::out_item_t  out_item
);

  import srtsch_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CAP, S_RESP,
    S_MV_RD, S_MV_CK,
    S_LS_RD, S_LS_CK,
    S_BS_RD, S_BS_CK,
    S_SO_LD, S_SO_W, S_SO_RD, S_SO_CK, S_SO_PUT,
    S_EM_RD, S_EM
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [AW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hp_r, hp_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [WORD_W-1:0] w_r, w_nxt;
  logic              hit_r, hit_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_pos_r, pend_pos_nxt;
  status_t           rsp_status_r, rsp_status_nxt;
  logic [WORD_W-1:0] rsp_value_r, rsp_value_nxt;
  logic [AW-1:0]     rsp_pos_r, rsp_pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] rd_data;

  logic              out_free;
  logic [CW-1:0]     cnt_m1;
  logic              i_last;
  logic              key_hit;
  logic              w_lt;
  logic              rd_lt_key;
  logic              key_bad;
  logic [CW-1:0]     span;
  logic [CW-1:0]     mid_w;
  logic [CW-1:0]     mid_p1;
  logic [AW-1:0]     mid;

  srtsch_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // shared compare unit and index arithmetic
  assign out_free  = !out_valid_r || !out_stall;
  assign cnt_m1    = cnt_r - CW'(1);
  assign i_last    = (i_r == cnt_m1);
  assign key_hit   = (rd_data == key_r);
  assign w_lt      = $signed(w_r) < $signed(rd_data);
  assign rd_lt_key = $signed(rd_data) < $signed(key_r);
  assign key_bad   = $unsigned(in_item.key) >= WORD_W'(cnt_r);
  assign span      = hp_r - lo_r - CW'(1);
  assign mid_w     = lo_r + (span >> 1);
  assign mid_p1    = mid_w + CW'(1);
  assign mid       = mid_w[AW-1:0];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    lo_nxt         = lo_r;
    hp_nxt         = hp_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    w_nxt          = w_r;
    hit_nxt        = hit_r;
    pend_nxt       = pend_r;
    pend_pos_nxt   = pend_pos_r;
    rsp_status_nxt = rsp_status_r;
    rsp_value_nxt  = rsp_value_r;
    rsp_pos_nxt    = rsp_pos_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_waddr      = i_r[AW-1:0];
    ram_wdata      = val_r;
    ram_raddr      = i_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt        = in_item.key;
          val_nxt        = in_item.new_value;
          rsp_status_nxt = ST_OK;
          rsp_value_nxt  = '0;
          rsp_pos_nxt    = '0;
          i_nxt          = '0;
          hit_nxt        = 1'b0;
          pend_nxt       = 1'b0;
          state_nxt      = S_RESP;
          case (in_item.req_type)
            REQ_PUSH: begin
              if (cnt_r == CW'(DEPTH)) begin
                rsp_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[AW-1:0];
                ram_wdata = in_item.new_value;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            REQ_BSEARCH: begin
              if (cnt_r == '0) begin
                rsp_status_nxt = ST_NOTFOUND;
              end else begin
                lo_nxt    = '0;
                hp_nxt    = cnt_r;
                state_nxt = S_BS_RD;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                rsp_status_nxt = ST_EMPTY;
              end else begin
                case (in_item.req_type)
                  REQ_POP: begin
                    cnt_nxt   = cnt_m1;
                    ram_raddr = cnt_m1[AW-1:0];
                    state_nxt = S_CAP;
                  end
                  REQ_MODPOS: begin
                    if (key_bad) begin
                      rsp_status_nxt = ST_BADPOS;
                    end else begin
                      ram_we    = 1'b1;
                      ram_waddr = in_item.key[AW-1:0];
                      ram_wdata = in_item.new_value;
                    end
                  end
                  REQ_READPOS: begin
                    if (key_bad) begin
                      rsp_status_nxt = ST_BADPOS;
                    end else begin
                      ram_raddr = in_item.key[AW-1:0];
                      state_nxt = S_CAP;
                    end
                  end
                  REQ_MODVAL:  state_nxt = S_MV_RD;
                  REQ_LSEARCH: state_nxt = S_LS_RD;
                  REQ_SORT: begin
                    if (cnt_r == CW'(1)) begin
                      state_nxt = S_EM_RD;
                    end else begin
                      i_nxt     = CW'(1);
                      state_nxt = S_SO_LD;
                    end
                  end
                  default: state_nxt = S_RESP;
                endcase
              end
            end
          endcase
        end
      end

      // capture read data for pop and read by position
      S_CAP: begin
        rsp_value_nxt = rd_data;
        state_nxt     = S_RESP;
      end

      // single final result
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_item_nxt.status          = rsp_status_r;
          out_item_nxt.result_value    = rsp_value_r;
          out_item_nxt.result_position = POS_W'(rsp_pos_r);
          out_item_nxt.fill_level      = FILL_W'(cnt_r);
          out_item_nxt.last            = 1'b1;
          state_nxt                    = S_IDLE;
        end
      end

      // modify by value: walk all filled entries
      S_MV_RD: state_nxt = S_MV_CK;
      S_MV_CK: begin
        if (key_hit) begin
          ram_we  = 1'b1;
          hit_nxt = 1'b1;
        end
        if (i_last) begin
          rsp_status_nxt = (hit_r || key_hit) ? ST_OK : ST_NOTFOUND;
          state_nxt      = S_RESP;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_MV_RD;
        end
      end

      // linear search: hold one match back to know which is last
      S_LS_RD: state_nxt = S_LS_CK;
      S_LS_CK: begin
        if (!(key_hit && pend_r && !out_free)) begin
          if (key_hit && pend_r) begin
            out_valid_nxt                = 1'b1;
            out_item_nxt.status          = ST_OK;
            out_item_nxt.result_value    = '0;
            out_item_nxt.result_position = POS_W'(pend_pos_r);
            out_item_nxt.fill_level      = FILL_W'(cnt_r);
            out_item_nxt.last            = 1'b0;
          end
          if (key_hit) begin
            pend_nxt     = 1'b1;
            pend_pos_nxt = i_r[AW-1:0];
          end
          if (i_last) begin
            state_nxt = S_RESP;
            if (key_hit) begin
              rsp_pos_nxt = i_r[AW-1:0];
            end else if (pend_r) begin
              rsp_pos_nxt = pend_pos_r;
            end else begin
              rsp_status_nxt = ST_NOTFOUND;
            end
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_LS_RD;
          end
        end
      end

      // binary search over [lo, hp)
      S_BS_RD: begin
        ram_raddr = mid;
        state_nxt = S_BS_CK;
      end
      S_BS_CK: begin
        ram_raddr = mid;
        if (key_hit) begin
          rsp_pos_nxt = mid;
          state_nxt   = S_RESP;
        end else if (rd_lt_key) begin
          lo_nxt = mid_p1;
          if (mid_p1 >= hp_r) begin
            rsp_status_nxt = ST_NOTFOUND;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_BS_RD;
          end
        end else begin
          hp_nxt = mid_w;
          if (lo_r >= mid_w) begin
            rsp_status_nxt = ST_NOTFOUND;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_BS_RD;
          end
        end
      end

      // insertion sort: load word i, shift larger words up
      S_SO_LD: state_nxt = S_SO_W;
      S_SO_W: begin
        w_nxt     = rd_data;
        j_nxt     = i_r[AW-1:0];
        state_nxt = S_SO_RD;
      end
      S_SO_RD: begin
        ram_raddr = j_r - AW'(1);
        state_nxt = S_SO_CK;
      end
      S_SO_CK: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        if (w_lt) begin
          ram_wdata = rd_data;
          j_nxt     = j_r - AW'(1);
          state_nxt = (j_r == AW'(1)) ? S_SO_PUT : S_SO_RD;
        end else begin
          ram_wdata = w_r;
          if (i_last) begin
            i_nxt     = '0;
            state_nxt = S_EM_RD;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_SO_LD;
          end
        end
      end
      S_SO_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = w_r;
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = S_EM_RD;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SO_LD;
        end
      end

      // emit the sorted contents
      S_EM_RD: state_nxt = S_EM;
      S_EM: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_item_nxt.status          = ST_OK;
          out_item_nxt.result_value    = rd_data;
          out_item_nxt.result_position = POS_W'(i_r);
          out_item_nxt.fill_level      = FILL_W'(cnt_r);
          out_item_nxt.last            = i_last;
          if (i_last) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    lo_r         <= lo_nxt;
    hp_r         <= hp_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    w_r          <= w_nxt;
    hit_r        <= hit_nxt;
    pend_r       <= pend_nxt;
    pend_pos_r   <= pend_pos_nxt;
    rsp_status_r <= rsp_status_nxt;
    rsp_value_r  <= rsp_value_nxt;
    rsp_pos_r    <= rsp_pos_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // fill count never exceeds the store depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count above depth");

  // every accepted item leaves idle, since each yields a result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("item accepted without starting work");

  // store writes only happen for an item in progress
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r != S_IDLE) || (in_valid && !in_stall)))
    else $error("store written while idle");

  // a push into a store with room grows it by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_item.req_type == REQ_PUSH) && (cnt_r != CW'(DEPTH)))
    |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("push did not grow the store");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for array_store_sort_search_core: stack push/pop, modify,
// sort, read and search requests checked against a shadow copy of the store.
// Depends on srtsch_pkg and the core RTL.
module tb_top;
  import srtsch_pkg::*;

  localparam int unsigned DEPTH          = DEPTH_DEF;
  localparam int          IDLE_PCT       = 27;
  localparam int          RANDOM_REQS    = 90;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          TAIL_CYCLES    = 200;
  localparam int          MAX_REPORTS    = 10;

  // one queued request; drain holds it back until all results are in
  typedef struct {
    in_item_t item;
    bit       drain;
  } pending_req_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  pending_req_t req_backlog[$];
  out_item_t    due_results[$];

  // shadow store
  logic signed [WORD_W-1:0] shadow_words[DEPTH];
  int unsigned              shadow_fill = 0;

  int  in_count = 0;
  int  err_cnt  = 0;
  int  idle_run = 0;
  logic quiet;

  // no idling on either side while this window of items goes through
  assign quiet = (in_count >= 50) && (in_count < 85);

  array_store_sort_search_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // append one expected result, fill level taken after the update
  task automatic add_result(input status_t st, input logic signed [WORD_W-1:0] v,
                            input int unsigned p, input bit lst);
    out_item_t r;
    r.status          = st;
    r.result_value    = v;
    r.result_position = p[POS_W-1:0];
    r.fill_level      = shadow_fill[FILL_W-1:0];
    r.last            = lst;
    due_results.push_back(r);
  endtask

  // work out the results of one accepted request and update the shadow store
  task automatic predict_request(input in_item_t it);
    logic signed [WORD_W-1:0] k;
    logic signed [WORD_W-1:0] w;
    logic [WORD_W-1:0]        k_pos;
    int                       lo, hi, mid, j;
    int unsigned              i, hits, last_hit;
    bit                       found;
    k     = it.key;
    k_pos = it.key;
    if (it.req_type == REQ_PUSH) begin
      if (shadow_fill >= DEPTH) begin
        add_result(ST_FULL, '0, 0, 1'b1);
      end else begin
        shadow_words[shadow_fill] = it.new_value;
        shadow_fill++;
        add_result(ST_OK, '0, 0, 1'b1);
      end
    end else if (it.req_type == REQ_BSEARCH) begin
      // probes filled entries only; no contents check on order
      lo    = 0;
      hi    = int'(shadow_fill) - 1;
      found = 1'b0;
      while (lo <= hi && !found) begin
        mid = lo + (hi - lo) / 2;
        if (shadow_words[mid] == k) found = 1'b1;
        else if (shadow_words[mid] < k) lo = mid + 1;
        else hi = mid - 1;
      end
      if (found) add_result(ST_OK, '0, mid, 1'b1);
      else add_result(ST_NOTFOUND, '0, 0, 1'b1);
    end else if (shadow_fill == 0) begin
      add_result(ST_EMPTY, '0, 0, 1'b1);
    end else begin
      case (it.req_type)
        REQ_POP: begin
          shadow_fill--;
          add_result(ST_OK, shadow_words[shadow_fill], 0, 1'b1);
        end
        REQ_MODPOS: begin
          if (k_pos >= shadow_fill) begin
            add_result(ST_BADPOS, '0, 0, 1'b1);
          end else begin
            shadow_words[k_pos] = it.new_value;
            add_result(ST_OK, '0, 0, 1'b1);
          end
        end
        REQ_MODVAL: begin
          hits = 0;
          for (i = 0; i < shadow_fill; i++) begin
            if (shadow_words[i] == k) begin
              shadow_words[i] = it.new_value;
              hits++;
            end
          end
          add_result((hits != 0) ? ST_OK : ST_NOTFOUND, '0, 0, 1'b1);
        end
        REQ_SORT: begin
          // ascending signed insertion sort, then every entry goes out
          for (i = 1; i < shadow_fill; i++) begin
            w = shadow_words[i];
            j = i;
            while (j > 0 && w < shadow_words[j-1]) begin
              shadow_words[j] = shadow_words[j-1];
              j--;
            end
            shadow_words[j] = w;
          end
          for (i = 0; i < shadow_fill; i++)
            add_result(ST_OK, shadow_words[i], i, (i + 1) == shadow_fill);
        end
        REQ_READPOS: begin
          if (k_pos >= shadow_fill) add_result(ST_BADPOS, '0, 0, 1'b1);
          else add_result(ST_OK, shadow_words[k_pos], 0, 1'b1);
        end
        default: begin
          // linear search: one result per match, last on the final match
          hits     = 0;
          last_hit = 0;
          for (i = 0; i < shadow_fill; i++)
            if (shadow_words[i] == k) last_hit = i;
          for (i = 0; i < shadow_fill; i++) begin
            if (shadow_words[i] == k) begin
              add_result(ST_OK, '0, i, i == last_hit);
              hits++;
            end
          end
          if (hits == 0) add_result(ST_NOTFOUND, '0, 0, 1'b1);
        end
      endcase
    end
  endtask

  // compare one delivered result with the oldest expectation
  task automatic check_result(input out_item_t got);
    out_item_t exp_r;
    if (due_results.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("unexpected result: status=%0d value=%0d pos=%0d fill=%0d last=%0d",
                 got.status, got.result_value, got.result_position, got.fill_level,
                 got.last);
    end else begin
      exp_r = due_results.pop_front();
      if (got.status !== exp_r.status || got.result_value !== exp_r.result_value ||
          got.result_position !== exp_r.result_position ||
          got.fill_level !== exp_r.fill_level || got.last !== exp_r.last) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
          $display("mismatch: exp status=%0d value=%0d pos=%0d fill=%0d last=%0d",
                   exp_r.status, exp_r.result_value, exp_r.result_position,
                   exp_r.fill_level, exp_r.last);
          $display("          got status=%0d value=%0d pos=%0d fill=%0d last=%0d",
                   got.status, got.result_value, got.result_position,
                   got.fill_level, got.last);
        end
      end
    end
  endtask

  task automatic add_req(input req_kind_t kind, input logic [WORD_W-1:0] k,
                         input logic [WORD_W-1:0] v, input bit drain);
    pending_req_t p;
    p.item.req_type  = kind;
    p.item.key       = k;
    p.item.new_value = v;
    p.drain          = drain;
    req_backlog.push_back(p);
  endtask

  // driver: predicts on acceptance, then presents the next item or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_request(in_item);
        in_count++;
      end
      if (!in_valid || !in_stall) begin
        if (req_backlog.size() == 0) begin
          in_valid <= 1'b0;
        end else if (req_backlog[0].drain && due_results.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
          in_valid <= 1'b0;
        end else begin
          in_item  <= req_backlog[0].item;
          in_valid <= 1'b1;
          req_backlog.pop_front();
        end
      end
    end
  end

  // monitor: random output stalls, result check, activity watchdog count
  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
      if (out_valid && !out_stall) check_result(out_item);
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0] pool[8];
    logic [WORD_W-1:0] k, v;
    req_kind_t         kind;
    int unsigned       pick;
    bit                timed_out;

    // directed: every kind on an empty store
    add_req(REQ_POP,     $urandom, $urandom, 1'b0);
    add_req(REQ_MODPOS,  0,        $urandom, 1'b0);
    add_req(REQ_MODVAL,  0,        $urandom, 1'b0);
    add_req(REQ_SORT,    $urandom, $urandom, 1'b0);
    add_req(REQ_READPOS, 0,        $urandom, 1'b0);
    add_req(REQ_LSEARCH, 0,        $urandom, 1'b0);
    add_req(REQ_BSEARCH, 0,        $urandom, 1'b0);
    // fill with extremes and duplicates, then push once more when full
    add_req(REQ_PUSH, $urandom, 32'h7FFF_FFFF, 1'b0);
    add_req(REQ_PUSH, $urandom, 32'h8000_0000, 1'b0);
    add_req(REQ_PUSH, $urandom, 32'hFFFF_FFFF, 1'b0);
    add_req(REQ_PUSH, $urandom, 32'h0000_0000, 1'b0);
    add_req(REQ_PUSH, $urandom, 32'd5,         1'b0);
    add_req(REQ_PUSH, $urandom, 32'hFFFF_FFFF, 1'b0);
    add_req(REQ_PUSH, $urandom, 32'hAAAA_AAAA, 1'b0);
    add_req(REQ_PUSH, $urandom, 32'h5555_5555, 1'b0);
    add_req(REQ_PUSH, $urandom, $urandom,      1'b1);
    // negative and one-past-end positions, then valid ones
    add_req(REQ_MODPOS,  32'hFFFF_FFFF, $urandom, 1'b0);
    add_req(REQ_READPOS, DEPTH,         $urandom, 1'b0);
    add_req(REQ_MODPOS,  DEPTH - 1,     32'd7,    1'b0);
    add_req(REQ_READPOS, DEPTH - 1,     $urandom, 1'b0);
    // two entries equal to -1 become 7, so 7 then sits in three places
    add_req(REQ_MODVAL,  32'hFFFF_FFFF, 32'd7,    1'b0);
    add_req(REQ_LSEARCH, 32'd7,         $urandom, 1'b0);
    add_req(REQ_SORT,    $urandom,      $urandom, 1'b0);
    add_req(REQ_BSEARCH, 32'h7FFF_FFFF, $urandom, 1'b0);
    add_req(REQ_BSEARCH, 32'd1,         $urandom, 1'b0);
    add_req(REQ_POP,     $urandom,      $urandom, 1'b0);

    // random part: values from a small pool so that searches and
    // modify-by-value hit often, with full-range words mixed in
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    for (int p = 4; p < 8; p++) pool[p] = $urandom;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if ($urandom_range(0, 9) == 0) pool[$urandom_range(0, 7)] = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = REQ_PUSH;
      else if (pick < 42) kind = REQ_POP;
      else if (pick < 51) kind = REQ_MODPOS;
      else if (pick < 60) kind = REQ_MODVAL;
      else if (pick < 70) kind = REQ_SORT;
      else if (pick < 80) kind = REQ_READPOS;
      else if (pick < 90) kind = REQ_LSEARCH;
      else kind = REQ_BSEARCH;
      if (kind == REQ_MODPOS || kind == REQ_READPOS)
        k = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, DEPTH);
      else
        k = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 7)];
      v = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 7)];
      // binary search mostly meets sorted contents
      if (kind == REQ_BSEARCH && $urandom_range(0, 1) == 1)
        add_req(REQ_SORT, $urandom, $urandom, 1'b0);
      add_req(kind, k, v, (n % 40) == 20);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // run until everything is sent and answered, or the watchdog trips
    timed_out = 1'b0;
    while (!(req_backlog.size() == 0 && !in_valid && due_results.size() == 0) &&
           !timed_out) begin
      @(posedge clk);
      if (idle_run > WATCHDOG_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);

    if (!timed_out && err_cnt == 0 && due_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/srtsch_pkg.sv
hdl/srtsch_ram.sv
hdl/array_store_sort_search_core.sv
bench/tb_top.sv
